### src/plat_pkg.sv
// Package for the price level aggregation table: sizes, codes and shared types.
// Used by every module under src; depends on nothing.
`timescale 1ns / 1ps
package plat_pkg;

    localparam int SYMBOLS  = 16;
    localparam int LEVELS   = 8;
    localparam int SYM_W    = 4;
    localparam int SYM_IDX_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
    localparam int LVL_IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PRICE_W  = 32;
    localparam int LOT_W    = 31;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    localparam logic [LOT_W-1:0] LOT_MAX = {LOT_W{1'b1}};

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_REMOVE,
        OP_QUERY,
        OP_NOP
    } t_op;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op                  op;
        logic                 in_range;
        logic [SYM_IDX_W-1:0] sym;
        logic [PRICE_W-1:0]   price;
        logic [LOT_W-1:0]     lots;
    } t_cmd;

endpackage

### src/plat_front.sv
// Front end: accepts input beats, decodes mode and checks the symbol range.
// Depends on plat_pkg.
`timescale 1ns / 1ps
module plat_front import plat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [SYM_W-1:0]   i_symbol_id,
    input  logic [PRICE_W-1:0] i_price,
    input  logic [LOT_W-1:0]   i_lot_size,
    output logic               o_cmd_valid,
    input  logic               i_cmd_ready,
    output t_cmd               o_cmd
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    // Decode the beat into a command.
    always_comb begin
        n_cmd = '0;
        unique case (i_mode)
            MODE_INSERT: n_cmd.op = OP_INSERT;
            MODE_REMOVE: n_cmd.op = OP_REMOVE;
            MODE_QUERY:  n_cmd.op = OP_QUERY;
            default:     n_cmd.op = OP_NOP;
        endcase
        n_cmd.in_range = ({{(32-SYM_W){1'b0}}, i_symbol_id} < 32'(SYMBOLS));
        n_cmd.sym      = SYM_IDX_W'(i_symbol_id);
        n_cmd.price    = i_price;
        n_cmd.lots     = i_lot_size;
    end

    assign o_ready     = !r_valid || i_cmd_ready;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // One-entry holding stage between front and back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

### src/plat_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on plat_pkg.
`timescale 1ns / 1ps
module plat_queue import plat_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       n_push;
    logic       n_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign n_push  = i_valid && o_ready;
    assign n_pop   = o_valid && i_ready;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (n_push) r_wp <= !r_wp;
            if (n_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, n_push} - {1'b0, n_pop};
        end
        if (n_push) r_mem[r_wp] <= i_cmd;
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");

endmodule

### src/plat_back.sv
// Back end: reads one symbol's level row, compares in parallel, writes back.
// Depends on plat_pkg.
`timescale 1ns / 1ps
module plat_back import plat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_ready,
    input  t_cmd               i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [PRICE_W-1:0] o_low_price,
    output logic [PRICE_W-1:0] o_high_price
);

    typedef enum logic { S_READ, S_EXEC } t_state;

    localparam int ROW_W = LEVELS * (PRICE_W + LOT_W);

    t_state                    r_state;
    logic [SYMBOLS-1:0]        r_present;
    logic [LEVELS-1:0]         r_valid_bits [SYMBOLS];
    logic [ROW_W-1:0]          r_row_mem [SYMBOLS];
    logic [ROW_W-1:0]          r_row;
    logic [LEVELS-1:0]         r_vrow;
    logic                      r_pres;
    t_cmd                      r_cmd;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [PRICE_W-1:0]        r_lo;
    logic [PRICE_W-1:0]        r_hi;

    logic [PRICE_W-1:0]        n_pr [LEVELS];
    logic [LOT_W-1:0]          n_lt [LEVELS];
    logic [LEVELS-1:0]         n_hit;
    logic [LEVELS-1:0]         n_free;
    logic                      n_any_hit;
    logic                      n_any_free;
    logic [LVL_IDX_W-1:0]      n_hit_idx;
    logic [LVL_IDX_W-1:0]      n_free_idx;
    logic [LOT_W:0]            n_sum;
    logic [LOT_W-1:0]          n_sat;
    logic [ROW_W-1:0]          n_wrow;
    logic                      n_wr;
    logic [LEVELS-1:0]         n_vnew;
    logic                      n_pnew;
    logic [1:0]                n_status;
    logic [PRICE_W-1:0]        n_lo;
    logic [PRICE_W-1:0]        n_hi;
    logic                      n_seen;
    logic                      n_exec;

    // The execute step runs once the output register is free or being emptied.
    assign n_exec       = (r_state == S_EXEC) && (!r_out_valid || i_ready);
    assign o_cmd_ready  = (r_state == S_READ);
    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_low_price  = r_lo;
    assign o_high_price = r_hi;

    // Unpack the row and compare every slot in parallel.
    always_comb begin
        for (int i = 0; i < LEVELS; i++) begin
            n_pr[i]   = r_row[i*(PRICE_W+LOT_W) +: PRICE_W];
            n_lt[i]   = r_row[i*(PRICE_W+LOT_W)+PRICE_W +: LOT_W];
            n_hit[i]  = r_vrow[i] && (n_pr[i] == r_cmd.price);
            n_free[i] = !r_vrow[i];
        end
        n_any_hit  = |n_hit;
        n_any_free = |n_free;
        n_hit_idx  = '0;
        n_free_idx = '0;
        for (int i = LEVELS-1; i >= 0; i--) begin
            if (n_hit[i])  n_hit_idx  = LVL_IDX_W'(i);
            if (n_free[i]) n_free_idx = LVL_IDX_W'(i);
        end
        n_sum = {1'b0, n_lt[n_hit_idx]} + {1'b0, r_cmd.lots};
        n_sat = n_sum[LOT_W] ? LOT_MAX : n_sum[LOT_W-1:0];
    end

    // Min and max over the valid slots of the row.
    always_comb begin
        n_lo   = '0;
        n_hi   = '0;
        n_seen = 1'b0;
        for (int i = 0; i < LEVELS; i++) begin
            if (r_vrow[i]) begin
                if (!n_seen || ($signed(n_pr[i]) < $signed(n_lo))) n_lo = n_pr[i];
                if (!n_seen || ($signed(n_pr[i]) > $signed(n_hi))) n_hi = n_pr[i];
                n_seen = 1'b1;
            end
        end
    end

    // Work out the write-back and the result.
    always_comb begin
        n_wrow   = r_row;
        n_wr     = 1'b0;
        n_vnew   = r_vrow;
        n_pnew   = r_pres;
        n_status = ST_OK;
        if (r_cmd.op != OP_NOP && !r_cmd.in_range) begin
            n_status = ST_NOT_FOUND;
        end else begin
            unique case (r_cmd.op)
                OP_INSERT: begin
                    n_pnew = 1'b1;
                    if (n_any_hit) begin
                        n_wrow[32'(n_hit_idx)*(PRICE_W+LOT_W)+PRICE_W +: LOT_W] = n_sat;
                        n_wr = 1'b1;
                    end else if (n_any_free) begin
                        n_wrow[32'(n_free_idx)*(PRICE_W+LOT_W) +: PRICE_W] = r_cmd.price;
                        n_wrow[32'(n_free_idx)*(PRICE_W+LOT_W)+PRICE_W +: LOT_W] =
                            r_cmd.lots;
                        n_vnew[n_free_idx] = 1'b1;
                        n_wr = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                OP_REMOVE: begin
                    if (!r_pres) begin
                        n_status = ST_NOT_FOUND;
                    end else begin
                        n_pnew = 1'b0;
                        n_vnew = '0;
                    end
                end
                OP_QUERY: begin
                    if (!r_pres) n_status = ST_NOT_FOUND;
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    // Sequencer: row read, then execute and write back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_READ;
            r_out_valid <= 1'b0;
            r_present   <= '0;
            for (int s = 0; s < SYMBOLS; s++) r_valid_bits[s] <= '0;
        end else begin
            if (n_exec) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_READ: begin
                    if (i_cmd_valid && o_cmd_ready) begin
                        r_cmd   <= i_cmd;
                        r_row   <= r_row_mem[i_cmd.sym];
                        r_vrow  <= r_valid_bits[i_cmd.sym];
                        r_pres  <= r_present[i_cmd.sym];
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (n_exec) begin
                        if (r_cmd.in_range && r_cmd.op != OP_NOP) begin
                            r_valid_bits[r_cmd.sym] <= n_vnew;
                            r_present[r_cmd.sym]    <= n_pnew;
                        end
                        r_status <= n_status;
                        r_lo     <= (r_cmd.op == OP_QUERY && n_status == ST_OK) ? n_lo : '0;
                        r_hi     <= (r_cmd.op == OP_QUERY && n_status == ST_OK) ? n_hi : '0;
                        r_state  <= S_READ;
                    end
                end
                default: r_state <= S_READ;
            endcase
        end
    end

    // Level storage row memory.
    always_ff @(posedge i_clk) begin
        if (n_exec && n_wr && r_cmd.in_range) begin
            r_row_mem[r_cmd.sym] <= n_wrow;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_exec |=> (r_state == S_READ && o_valid))
        else $error("execute did not produce a result");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_low_price == '0 && o_high_price == '0))
        else $error("full status with nonzero prices");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)))
        else $error("stalled result changed");

endmodule

### src/price_level_aggregation_table_unit.sv
// Top level of the price level aggregation table.
// Depends on plat_pkg, plat_front, plat_queue and plat_back.
`timescale 1ns / 1ps
// Each beat passes through the back end's read step, which reads the symbol's
// level row, and its execute step, which compares, updates and writes it back.
// The back end reads the next row while a result waits in the output register;
// a result that is not taken holds the back end in its execute step. The front
// end and a two-entry queue take beats while the back end works. The level
// store needs no clearing pass: valid bits are cleared at reset.
module price_level_aggregation_table_unit import plat_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_mode,
    input  logic [SYM_W-1:0]   i_symbol_id,
    input  logic [PRICE_W-1:0] i_price,
    input  logic [LOT_W-1:0]   i_lot_size,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [1:0]         o_status,
    output logic [PRICE_W-1:0] o_low_price,
    output logic [PRICE_W-1:0] o_high_price
);

    logic f_valid, f_ready, q_valid, q_ready;
    t_cmd f_cmd, q_cmd;

    plat_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_mode, .i_symbol_id, .i_price,
        .i_lot_size, .o_cmd_valid(f_valid), .i_cmd_ready(f_ready), .o_cmd(f_cmd)
    );

    plat_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(f_valid), .o_ready(f_ready), .i_cmd(f_cmd),
        .o_valid(q_valid), .i_ready(q_ready), .o_cmd(q_cmd)
    );

    plat_back u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(q_valid), .o_cmd_ready(q_ready), .i_cmd(q_cmd),
        .o_valid, .i_ready, .o_status, .o_low_price, .o_high_price
    );

endmodule

### tb/tb_price_level_aggregation_table_unit.sv
// Testbench for the price level aggregation table: directed and random beats,
// a self-contained table predictor and an in-order result check.
// Depends on plat_pkg and price_level_aggregation_table_unit.
`timescale 1ns / 1ps
module tb_price_level_aggregation_table_unit;
    import plat_pkg::*;

    typedef struct packed {
        logic [1:0]         mode;
        logic [SYM_W-1:0]   sym;
        logic [PRICE_W-1:0] price;
        logic [LOT_W-1:0]   lots;
    } t_order;

    typedef struct packed {
        logic [1:0]         status;
        logic [PRICE_W-1:0] lo;
        logic [PRICE_W-1:0] hi;
    } t_reply;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_mode;
    logic [SYM_W-1:0]   i_symbol_id;
    logic [PRICE_W-1:0] i_price;
    logic [LOT_W-1:0]   i_lot_size;
    logic               o_valid;
    logic               i_ready;
    logic [1:0]         o_status;
    logic [PRICE_W-1:0] o_low_price;
    logic [PRICE_W-1:0] o_high_price;

    price_level_aggregation_table_unit u_dut (.*);

    // Predicted book state.
    logic                     book_sym_live [SYMBOLS];
    logic                     book_lvl_live [SYMBOLS][LEVELS];
    logic signed [PRICE_W-1:0] book_lvl_px  [SYMBOLS][LEVELS];
    logic [LOT_W-1:0]         book_lvl_lots [SYMBOLS][LEVELS];

    t_order pending_orders[$];
    t_reply expected_replies[$];
    int     mismatch_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_receiver = 0;

    // Apply one order to the predicted book and return its reply.
    function automatic t_reply book_apply(t_order o);
        t_reply r;
        int free_slot;
        bit found;
        bit any;
        logic [LOT_W:0] sum;
        r = '0;
        free_slot = -1;
        found = 0;
        any = 0;
        if (o.mode == MODE_NONE) begin
            r.status = ST_OK;
        end else if (int'(o.sym) >= SYMBOLS) begin
            r.status = ST_NOT_FOUND;
        end else if (o.mode == MODE_INSERT) begin
            book_sym_live[o.sym] = 1'b1;
            r.status = ST_OK;
            for (int i = 0; i < LEVELS && !found; i++) begin
                if (book_lvl_live[o.sym][i] && book_lvl_px[o.sym][i] == o.price) begin
                    sum = {1'b0, book_lvl_lots[o.sym][i]} + {1'b0, o.lots};
                    book_lvl_lots[o.sym][i] = sum[LOT_W] ? LOT_MAX : sum[LOT_W-1:0];
                    found = 1;
                end else if (!book_lvl_live[o.sym][i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (!found) begin
                if (free_slot < 0) begin
                    r.status = ST_FULL;
                end else begin
                    book_lvl_live[o.sym][free_slot] = 1'b1;
                    book_lvl_px[o.sym][free_slot] = o.price;
                    book_lvl_lots[o.sym][free_slot] = o.lots;
                end
            end
        end else if (!book_sym_live[o.sym]) begin
            r.status = ST_NOT_FOUND;
        end else if (o.mode == MODE_REMOVE) begin
            book_sym_live[o.sym] = 1'b0;
            for (int i = 0; i < LEVELS; i++) book_lvl_live[o.sym][i] = 1'b0;
        end else begin
            for (int i = 0; i < LEVELS; i++) begin
                if (book_lvl_live[o.sym][i]) begin
                    if (!any || $signed(book_lvl_px[o.sym][i]) < $signed(r.lo))
                        r.lo = book_lvl_px[o.sym][i];
                    if (!any || $signed(book_lvl_px[o.sym][i]) > $signed(r.hi))
                        r.hi = book_lvl_px[o.sym][i];
                    any = 1;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // Append one order to the pending list of the driver.
    task automatic add_order(t_order o);
        pending_orders = {pending_orders, o};
    endtask

    // Prices are mostly drawn from a small pool so that levels aggregate and fill up.
    function automatic t_order random_order();
        t_order o;
        int pick;
        o.sym = SYM_W'($urandom_range(0, 5) == 0 ? $urandom : $urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        o.mode = pick < 65 ? MODE_INSERT : pick < 75 ? MODE_REMOVE :
                 pick < 97 ? MODE_QUERY : MODE_NONE;
        case ($urandom_range(0, 3))
            0: o.price = $urandom;
            1: o.price = 32'h7FFF_FFF0 + $urandom_range(0, 15);
            default: o.price = $urandom_range(0, 11) - 6;
        endcase
        o.lots = LOT_W'($urandom_range(0, 3) == 0 ? 32'h7FFF_FF00 + $urandom_range(0, 255)
                                                   : $urandom);
        return o;
    endfunction

    function automatic t_order mk(logic [1:0] m, int s, logic [31:0] p, int l);
        t_order o;
        o.mode = m;
        o.sym = SYM_W'(s);
        o.price = p;
        o.lots = LOT_W'(l);
        return o;
    endfunction

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Driver: offers the queue head, predicts at acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                t_reply r;
                r = book_apply({i_mode, i_symbol_id, i_price, i_lot_size});
                expected_replies = {expected_replies, r};
            end
            if ((!i_valid || o_ready) && pending_orders.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
                t_order o;
                o = pending_orders.pop_front();
                i_valid     <= 1'b1;
                i_mode      <= o.mode;
                i_symbol_id <= o.sym;
                i_price     <= o.price;
                i_lot_size  <= o.lots;
            end else if (i_valid && o_ready) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each result beat against the oldest prediction.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        i_ready <= !hold_receiver && $urandom_range(0, 99) >= recv_stall_pct;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_replies.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_status), 32'd0);
            end else begin
                t_reply e;
                e = expected_replies.pop_front();
                if (o_status !== e.status)
                    report_mismatch("status", 32'(o_status), 32'(e.status));
                if (o_low_price !== e.lo) report_mismatch("low_price", o_low_price, e.lo);
                if (o_high_price !== e.hi) report_mismatch("high_price", o_high_price, e.hi);
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("price_level_aggregation_table_unit: mismatch");
            $finish;
        end
    end

    task automatic drain();
        while (pending_orders.size() > 0 || i_valid || expected_replies.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        for (int s = 0; s < SYMBOLS; s++) begin
            book_sym_live[s] = 0;
            for (int i = 0; i < LEVELS; i++) book_lvl_live[s][i] = 0;
        end
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        i_mode = MODE_NONE;
        i_symbol_id = '0;
        i_price = '0;
        i_lot_size = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: absent symbol, extremes, saturation, full table, mode 3.
        add_order(mk(MODE_QUERY, 0, 0, 0));
        add_order(mk(MODE_REMOVE, 0, 0, 0));
        add_order(mk(MODE_INSERT, 15, 32'h8000_0000, 0));
        add_order(mk(MODE_INSERT, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_order(mk(MODE_INSERT, 15, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        add_order(mk(MODE_QUERY, 15, 0, 0));
        for (int i = 0; i < LEVELS + 1; i++)
            add_order(mk(MODE_INSERT, 3, i * 7 - 20, i));
        add_order(mk(MODE_QUERY, 3, 0, 0));
        add_order(mk(MODE_REMOVE, 3, 0, 0));
        add_order(mk(MODE_QUERY, 3, 0, 0));
        add_order(mk(MODE_NONE, 15, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        add_order(mk(MODE_INSERT, 7, 5, 0));
        add_order(mk(MODE_REMOVE, 7, 0, 0));
        add_order(mk(MODE_QUERY, 7, 0, 0));
        drain();

        // Random phases under different idle and stall rates.
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = ph == 1 || ph == 3 ? 68 : 0;
            recv_stall_pct = ph == 2 || ph == 3 ? (ph == 3 ? 19 : 68) : 0;
            if (ph == 3) send_idle_pct = 19;
            for (int n = 0; n < 450; n++) add_order(random_order());
            if (ph == 0) begin
                // Long receiver hold-off so the block backs up.
                hold_receiver = 1;
                repeat (60) @(posedge i_clk);
                hold_receiver = 0;
            end
            drain();
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("price_level_aggregation_table_unit: match");
        else
            $display("price_level_aggregation_table_unit: mismatch");
        $finish;
    end
endmodule
